// ===== sv/ppfe_pkg.sv =====
// Package for the channel pair FIFO engine: operation and status codes,
// field widths and default sizes. Depends on nothing.
`default_nettype none

package ppfe_pkg;

  // Default sizes.
  localparam int DEF_NUM_PAIRS = 8;
  localparam int DEF_BUF_DEPTH = 4096;

  // Field widths of the request and result beats.
  localparam int OP_W     = 3;
  localparam int PAIR_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;

  // Request operations.
  localparam logic [OP_W-1:0] OP_ALLOC        = 3'd0;
  localparam logic [OP_W-1:0] OP_OPEN_SLAVE   = 3'd1;
  localparam logic [OP_W-1:0] OP_MASTER_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_MASTER_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_SLAVE_WRITE  = 3'd4;
  localparam logic [OP_W-1:0] OP_SLAVE_READ   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLOSE_MASTER = 3'd6;
  localparam logic [OP_W-1:0] OP_CLOSE_SLAVE  = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EOF      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_AGAIN    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd6;

endpackage

`default_nettype wire

// ===== sv/pty_pair_fifo_engine.sv =====
// Top level of the channel pair FIFO engine: request/result streams,
// pair control memory and the two byte ring buffer memories. Uses ppfe_pkg.
//
// The engine serves one request at a time. A request beat is taken when the
// engine is idle; it reads the pair's control word (pointers and fill counts)
// from a synchronous memory, decides and writes back in the next cycle, and
// a successful read then passes through a data step for the byte memory. A
// request holds the engine through accept, decide and result load, plus the
// data step for a read that returns a byte; the result load waits while an
// earlier result beat has not been taken. The result register lets the next
// request start while a result still waits to be taken. The pair flags live
// in flip-flops; a control word never written since reset reads as zero
// through a per-pair valid bit, so no clearing pass is needed.
`default_nettype none

module pty_pair_fifo_engine #(
  parameter int NUM_PAIRS = ppfe_pkg::DEF_NUM_PAIRS,
  parameter int BUF_DEPTH = ppfe_pkg::DEF_BUF_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Request stream.
  input  wire logic                      in_tvalid,
  output      logic                      in_tready,
  // Bits from 0: op[2:0], pair[5:3], data_in[13:6], zero[15:14].
  input  wire logic [ppfe_pkg::IN_W-1:0]  in_tdata,
  // Result stream.
  output      logic                      out_tvalid,
  input  wire logic                      out_tready,
  // Bits from 0: status[2:0], data_out[10:3], pair_out[13:11],
  // master_has_data[14], slave_has_data[15].
  output      logic [ppfe_pkg::OUT_W-1:0] out_tdata
);

  localparam int PW    = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int PTRW  = $clog2(BUF_DEPTH);
  localparam int FW    = $clog2(BUF_DEPTH + 1);
  localparam int EW    = 2 * (2 * PTRW + FW);
  localparam int MEM_DEPTH = NUM_PAIRS * BUF_DEPTH;
  localparam int AW    = $clog2(MEM_DEPTH);
  localparam logic [PTRW-1:0] PTR_LAST = PTRW'(BUF_DEPTH - 1);
  localparam logic [FW-1:0]   FILL_MAX = FW'(BUF_DEPTH);

  // Sequencer codes.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CTRL = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Request fields.
  logic [ppfe_pkg::OP_W-1:0]   in_op;
  logic [ppfe_pkg::PAIR_W-1:0] in_pair;
  logic [ppfe_pkg::BYTE_W-1:0] in_din;
  logic [6:0]                  in_pair_ext;
  logic [PW-1:0]               in_idx;
  logic                        in_fire;

  assign in_op       = in_tdata[2:0];
  assign in_pair     = in_tdata[5:3];
  assign in_din      = in_tdata[13:6];
  assign in_pair_ext = {4'b0, in_pair};
  assign in_idx      = in_pair_ext[PW-1:0];
  assign in_tready   = (state_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;

  // Latched request.
  logic [ppfe_pkg::OP_W-1:0]   req_op_r;
  logic [ppfe_pkg::PAIR_W-1:0] req_pair_r;
  logic [ppfe_pkg::BYTE_W-1:0] req_din_r;

  // Pair flags and control word valid bits.
  logic [NUM_PAIRS-1:0] active_r, mopen_r, sopen_r, ctrl_vld_r;
  logic [NUM_PAIRS-1:0] active_nxt, mopen_nxt, sopen_nxt, ctrl_vld_nxt;

  // Control word memory: pointers and fill counts of both directions.
  logic [EW-1:0] ctrl_mem [NUM_PAIRS];
  logic [EW-1:0] ctrl_q_r;
  logic          ent_vld_r;
  logic          ctrl_we;
  logic [PW-1:0] ctrl_waddr;
  logic [EW-1:0] ctrl_wdata;

  // Byte memories.
  logic [ppfe_pkg::BYTE_W-1:0] ts_mem [MEM_DEPTH];
  logic [ppfe_pkg::BYTE_W-1:0] tm_mem [MEM_DEPTH];
  logic [ppfe_pkg::BYTE_W-1:0] ts_q_r, tm_q_r;
  logic                        ts_we, tm_we, ts_re, tm_re;
  logic [AW-1:0]               mem_addr;

  // Pending result.
  logic [ppfe_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [ppfe_pkg::BYTE_W-1:0]   res_data_r;
  logic [ppfe_pkg::PAIR_W-1:0]   res_pair_r, res_pair_nxt;
  logic                          res_mhd_r, res_mhd_nxt;
  logic                          res_shd_r, res_shd_nxt;
  logic                          rd_tm_r, rd_tm_nxt;

  // Output register.
  logic                       out_valid_r;
  logic [ppfe_pkg::OUT_W-1:0] out_data_r;
  logic                       out_load;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // Control word memory: read at accept, written back in the decide cycle.
  always_ff @(posedge clk) begin
    if (ctrl_we) begin
      ctrl_mem[ctrl_waddr] <= ctrl_wdata;
    end
    if (in_fire) begin
      ctrl_q_r <= ctrl_mem[in_idx];
    end
  end

  // Master-to-slave byte memory.
  always_ff @(posedge clk) begin
    if (ts_we) begin
      ts_mem[mem_addr] <= req_din_r;
    end
    if (ts_re) begin
      ts_q_r <= ts_mem[mem_addr];
    end
  end

  // Slave-to-master byte memory.
  always_ff @(posedge clk) begin
    if (tm_we) begin
      tm_mem[mem_addr] <= req_din_r;
    end
    if (tm_re) begin
      tm_q_r <= tm_mem[mem_addr];
    end
  end

  // Decide cycle: status, new flags, new control word and memory accesses.
  logic [6:0]      req_pair_ext;
  logic [PW-1:0]   req_idx;
  logic            in_range;
  logic            found;
  logic [PW-1:0]   free_idx;
  logic [6:0]      free_ext;
  logic [EW-1:0]   entry;
  logic [PTRW-1:0] ts_wp, ts_rp, tm_wp, tm_rp;
  logic [FW-1:0]   ts_fill, tm_fill;
  logic [PTRW-1:0] ts_wp_n, ts_rp_n, tm_wp_n, tm_rp_n;
  logic [FW-1:0]   ts_fill_n, tm_fill_n;
  logic [PTRW-1:0] acc_ptr;
  logic            rd_ok;

  assign req_pair_ext = {4'b0, req_pair_r};
  assign req_idx      = req_pair_ext[PW-1:0];
  assign in_range     = (req_pair_ext < 7'(NUM_PAIRS));
  assign entry        = ent_vld_r ? ctrl_q_r : '0;
  assign free_ext     = 7'(free_idx);
  assign mem_addr     = AW'(32'(ctrl_waddr) * BUF_DEPTH + 32'(acc_ptr));

  // Lowest inactive pair.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NUM_PAIRS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        found    = 1'b1;
        free_idx = PW'(i);
      end
    end
  end

  always_comb begin
    {ts_wp, ts_rp, ts_fill, tm_wp, tm_rp, tm_fill} = entry;
    ts_wp_n        = ts_wp;
    ts_rp_n        = ts_rp;
    ts_fill_n      = ts_fill;
    tm_wp_n        = tm_wp;
    tm_rp_n        = tm_rp;
    tm_fill_n      = tm_fill;
    active_nxt     = active_r;
    mopen_nxt      = mopen_r;
    sopen_nxt      = sopen_r;
    ctrl_vld_nxt   = ctrl_vld_r;
    ctrl_we        = 1'b0;
    ctrl_waddr     = req_idx;
    ts_we          = 1'b0;
    tm_we          = 1'b0;
    ts_re          = 1'b0;
    tm_re          = 1'b0;
    acc_ptr        = '0;
    rd_ok          = 1'b0;
    rd_tm_nxt      = rd_tm_r;
    res_status_nxt = ppfe_pkg::ST_OK;
    res_pair_nxt   = req_pair_r;
    res_mhd_nxt    = 1'b0;
    res_shd_nxt    = 1'b0;

    if (state_r == S_CTRL) begin
      if (req_op_r == ppfe_pkg::OP_ALLOC) begin
        if (found) begin
          // Fresh pair: empty buffers, master side open.
          active_nxt[free_idx]   = 1'b1;
          mopen_nxt[free_idx]    = 1'b1;
          sopen_nxt[free_idx]    = 1'b0;
          ctrl_vld_nxt[free_idx] = 1'b1;
          ctrl_we      = 1'b1;
          ctrl_waddr   = free_idx;
          res_pair_nxt = free_ext[2:0];
          ts_wp_n = '0; ts_rp_n = '0; ts_fill_n = '0;
          tm_wp_n = '0; tm_rp_n = '0; tm_fill_n = '0;
        end else begin
          res_status_nxt = ppfe_pkg::ST_NOFREE;
        end
      end else if (!in_range) begin
        res_status_nxt = ppfe_pkg::ST_INACTIVE;
      end else if (req_op_r == ppfe_pkg::OP_CLOSE_MASTER) begin
        mopen_nxt[req_idx] = 1'b0;
        if (!sopen_r[req_idx]) begin
          active_nxt[req_idx] = 1'b0;
        end
      end else if (req_op_r == ppfe_pkg::OP_CLOSE_SLAVE) begin
        sopen_nxt[req_idx] = 1'b0;
        if (!mopen_r[req_idx]) begin
          active_nxt[req_idx] = 1'b0;
        end
      end else if (!active_r[req_idx]) begin
        res_status_nxt = ppfe_pkg::ST_INACTIVE;
      end else begin
        unique case (req_op_r)
          ppfe_pkg::OP_OPEN_SLAVE: begin
            sopen_nxt[req_idx] = 1'b1;
          end
          ppfe_pkg::OP_MASTER_WRITE: begin
            if (ts_fill >= FILL_MAX) begin
              res_status_nxt = ppfe_pkg::ST_FULL;
            end else begin
              ts_we     = 1'b1;
              acc_ptr   = ts_wp;
              ts_wp_n   = (ts_wp == PTR_LAST) ? '0 : ts_wp + 1'b1;
              ts_fill_n = ts_fill + 1'b1;
              ctrl_we   = 1'b1;
            end
          end
          ppfe_pkg::OP_SLAVE_WRITE: begin
            if (tm_fill >= FILL_MAX) begin
              res_status_nxt = ppfe_pkg::ST_FULL;
            end else begin
              tm_we     = 1'b1;
              acc_ptr   = tm_wp;
              tm_wp_n   = (tm_wp == PTR_LAST) ? '0 : tm_wp + 1'b1;
              tm_fill_n = tm_fill + 1'b1;
              ctrl_we   = 1'b1;
            end
          end
          ppfe_pkg::OP_MASTER_READ: begin
            if (tm_fill == '0) begin
              res_status_nxt = ppfe_pkg::ST_EMPTY;
            end else begin
              tm_re     = 1'b1;
              rd_ok     = 1'b1;
              rd_tm_nxt = 1'b1;
              acc_ptr   = tm_rp;
              tm_rp_n   = (tm_rp == PTR_LAST) ? '0 : tm_rp + 1'b1;
              tm_fill_n = tm_fill - 1'b1;
              ctrl_we   = 1'b1;
            end
          end
          ppfe_pkg::OP_SLAVE_READ: begin
            if (ts_fill == '0) begin
              res_status_nxt = mopen_r[req_idx] ? ppfe_pkg::ST_AGAIN : ppfe_pkg::ST_EOF;
            end else begin
              ts_re     = 1'b1;
              rd_ok     = 1'b1;
              rd_tm_nxt = 1'b0;
              acc_ptr   = ts_rp;
              ts_rp_n   = (ts_rp == PTR_LAST) ? '0 : ts_rp + 1'b1;
              ts_fill_n = ts_fill - 1'b1;
              ctrl_we   = 1'b1;
            end
          end
          default: begin
            res_status_nxt = ppfe_pkg::ST_OK;
          end
        endcase
      end

      // Has-data flags of the reported pair after this request.
      if (in_range || (req_op_r == ppfe_pkg::OP_ALLOC && found)) begin
        res_mhd_nxt = (tm_fill_n != '0);
        res_shd_nxt = (ts_fill_n != '0);
      end
    end

    ctrl_wdata = {ts_wp_n, ts_rp_n, ts_fill_n, tm_wp_n, tm_rp_n, tm_fill_n};
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_CTRL;
        end
      end
      S_CTRL: begin
        state_nxt = rd_ok ? S_DATA : S_DONE;
      end
      S_DATA: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      mopen_r     <= '0;
      sopen_r     <= '0;
      ctrl_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      active_r   <= active_nxt;
      mopen_r    <= mopen_nxt;
      sopen_r    <= sopen_nxt;
      ctrl_vld_r <= ctrl_vld_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, pending result and output payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op_r   <= in_op;
      req_pair_r <= in_pair;
      req_din_r  <= in_din;
      ent_vld_r  <= ctrl_vld_r[in_idx];
    end
    if (state_r == S_CTRL) begin
      res_status_r <= res_status_nxt;
      res_pair_r   <= res_pair_nxt;
      res_mhd_r    <= res_mhd_nxt;
      res_shd_r    <= res_shd_nxt;
      res_data_r   <= '0;
      rd_tm_r      <= rd_tm_nxt;
    end
    if (state_r == S_DATA) begin
      res_data_r <= rd_tm_r ? tm_q_r : ts_q_r;
    end
    if (out_load) begin
      out_data_r <= {res_shd_r, res_mhd_r, res_pair_r, res_data_r, res_status_r};
    end
  end

endmodule

`default_nettype wire
